@@ hdl/gsae_pkg.sv @@
// Shared constants, types and elaboration-time tables for the Gaussian ball evaluator.
// Used by gsae_cordic, gaussian_sphere_anomaly_eval and tb_top; depends on nothing.
package gsae_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int CORDIC_W     = 34;

    typedef logic signed [CORDIC_W-1:0] cordic_word_t;

    localparam cordic_word_t CORDIC_GAIN = 34'sd652032874;

    localparam cordic_word_t ATAN_ROM [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef enum logic [2:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_CENTER_Z     = 3'd2,
        REG_BALL_RADIUS  = 3'd3,
        REG_HALF_WIDTH   = 3'd4,
        REG_VALUE_INSIDE = 3'd5
    } cfg_reg_t;

    localparam int SQRT_STEPS = 30;
    localparam int SUM_W      = 61;
    localparam int DIST_W     = 31;
    localparam int DIV_STEPS  = 19;
    localparam int DIV_W      = DIST_W + 16;
    localparam int FRAC_BITS  = 16;
    localparam int EXP_STEPS  = 16;
    localparam int GAIN_W     = 31;

    localparam logic [GAIN_W-1:0] ONE_Q30 = 31'h4000_0000;

    typedef logic [GAIN_W-1:0] coef_t;
    typedef coef_t coef_rom_t [EXP_STEPS];

    typedef struct packed {
        logic oor;
        logic dz;
    } tag_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // c_k = 2^30 * 2^(-2^-(k+1)), built by repeated square roots
    function automatic coef_rom_t build_exp_rom();
        coef_rom_t   rom;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int k = 0; k < EXP_STEPS; k++)
        begin
            rom[k] = c[GAIN_W-1:0];
            c      = isqrt64(c << 30);
        end
        return rom;
    endfunction

    localparam coef_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ hdl/gsae_cordic.sv @@
// Pipelined CORDIC sine/cosine of a 16-bit binary angle, Q30 results.
// Depends on gsae_pkg for the gain, arctangent table and word types.
module gsae_cordic
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        ang,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    localparam int N = gsae_pkg::CORDIC_STEPS;
    localparam int W = gsae_pkg::CORDIC_W;

    logic [31:0] a_turn;
    logic        flip;
    logic [31:0] a_rot;

    gsae_pkg::cordic_word_t x_reg [N+1];
    gsae_pkg::cordic_word_t y_reg [N+1];
    gsae_pkg::cordic_word_t z_reg [N+1];
    logic                   flip_reg [N+1];
    logic signed [31:0]     sin_reg;
    logic signed [31:0]     cos_reg;

    // fold angles in the left half plane by a half turn
    assign a_turn = {ang, 16'h0000};
    assign flip   = a_turn[31] ^ a_turn[30];
    assign a_rot  = {a_turn[31] ^ flip, a_turn[30:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= gsae_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(W-32){a_rot[31]}}, a_rot};
            flip_reg[0] <= flip;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - gsae_pkg::ATAN_ROM[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + gsae_pkg::ATAN_ROM[i];
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= flip_reg[N] ? 32'(-y_reg[N]) : y_reg[N][31:0];
            cos_reg <= flip_reg[N] ? 32'(-x_reg[N]) : x_reg[N][31:0];
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

@@ hdl/gaussian_sphere_anomaly_eval.sv @@
// Top level of the Gaussian ball anomaly evaluator: the full datapath pipeline.
// Depends on gsae_pkg and instantiates gsae_cordic twice.
//
// The block accepts one query point per clock while the output side keeps taking results, and
// returns one result per point, in order. Every step (two 26-stage CORDIC units of load, 24
// rotations and sign fix, the coordinate multiplies, the 30-stage square root, the 19-stage
// divider and the 16-stage power-of-two taper) is its own register stage, so the throughput
// is one item per cycle; the whole pipe holds as one when a finished result waits at the
// output, and in_ready then drops until that result is taken. Write the six configuration
// registers only while no item is in flight.
module gaussian_sphere_anomaly_eval
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // query point
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [22:0]        point_radius,
    input  logic [15:0]        colatitude,
    input  logic [15:0]        longitude,
    // result
    output logic               out_valid,
    input  logic               out_ready,
    output logic               in_range,
    output logic signed [31:0] perturbation
);

    localparam int LAT     = gsae_pkg::CORDIC_LAT;
    localparam int P_CRD   = LAT - 1;
    localparam int P_M1    = P_CRD + 1;
    localparam int P_M2    = P_M1 + 1;
    localparam int P_ABS   = P_M2 + 1;
    localparam int P_SQ    = P_ABS + 1;
    localparam int P_SUM   = P_SQ + 1;
    localparam int P_ROOT  = P_SUM + gsae_pkg::SQRT_STEPS;
    localparam int P_D     = P_ROOT + 1;
    localparam int P_DIV   = P_D + gsae_pkg::DIV_STEPS;
    localparam int P_T     = P_DIV + 1;
    localparam int P_EXP   = P_T + gsae_pkg::EXP_STEPS;
    localparam int P_SH    = P_EXP + 1;
    localparam int P_MUL   = P_SH + 1;
    localparam int P_OUT   = P_MUL + 1;
    localparam int DEPTH   = P_OUT + 1;
    localparam int SQ_N    = gsae_pkg::SQRT_STEPS;
    localparam int DIV_N   = gsae_pkg::DIV_STEPS;
    localparam int EXP_N   = gsae_pkg::EXP_STEPS;
    localparam int SUM_W   = gsae_pkg::SUM_W;
    localparam int DIV_W   = gsae_pkg::DIV_W;
    localparam int DIST_W  = gsae_pkg::DIST_W;
    localparam int FRAC    = gsae_pkg::FRAC_BITS;
    localparam int GW      = gsae_pkg::GAIN_W;

    // ---------------- configuration registers ----------------
    logic signed [23:0] center_x_reg;
    logic signed [23:0] center_y_reg;
    logic signed [23:0] center_z_reg;
    logic [22:0]        ball_radius_reg;
    logic [22:0]        half_width_reg;
    logic signed [31:0] value_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            ball_radius_reg  <= '0;
            half_width_reg   <= '0;
            value_inside_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (gsae_pkg::cfg_reg_t'(cfg_index))
                gsae_pkg::REG_CENTER_X:     center_x_reg     <= cfg_data[23:0];
                gsae_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_data[23:0];
                gsae_pkg::REG_CENTER_Z:     center_z_reg     <= cfg_data[23:0];
                gsae_pkg::REG_BALL_RADIUS:  ball_radius_reg  <= cfg_data[22:0];
                gsae_pkg::REG_HALF_WIDTH:   half_width_reg   <= cfg_data[22:0];
                gsae_pkg::REG_VALUE_INSIDE: value_inside_reg <= cfg_data;
                default: ;  // unused indexes: drop the write
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // One enable moves every stage; a held result freezes the whole pipe.
    logic en;
    logic vld_reg [DEPTH];

    assign en       = !vld_reg[P_OUT] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j < DEPTH; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    // ---------------- angles: two CORDIC units ----------------
    logic signed [31:0] sin_th;
    logic signed [31:0] cos_th;
    logic signed [31:0] sin_ph;
    logic signed [31:0] cos_ph;
    logic [22:0]        r_reg [LAT];

    gsae_cordic u_cordic_th
    (
        .clk     (clk),
        .en      (en),
        .ang     (colatitude),
        .sin_q30 (sin_th),
        .cos_q30 (cos_th)
    );

    gsae_cordic u_cordic_ph
    (
        .clk     (clk),
        .en      (en),
        .ang     (longitude),
        .sin_q30 (sin_ph),
        .cos_q30 (cos_ph)
    );

    // hold the radius alongside the CORDIC latency
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= point_radius;
            for (int j = 1; j < LAT; j++)
            begin
                r_reg[j] <= r_reg[j-1];
            end
        end
    end

    // ---------------- Cartesian coordinates, Q4 metres ----------------
    logic signed [55:0] rs_prod;
    logic signed [55:0] pz_prod;
    logic signed [29:0] rs_reg;
    logic signed [29:0] pz_reg;
    logic signed [31:0] cp_reg;
    logic signed [31:0] sp_reg;
    logic signed [61:0] px_prod;
    logic signed [61:0] py_prod;
    logic signed [29:0] px_reg;
    logic signed [29:0] py_reg;
    logic signed [29:0] pz2_reg;

    assign rs_prod = $signed({1'b0, r_reg[P_CRD]}) * sin_th;
    assign pz_prod = $signed({1'b0, r_reg[P_CRD]}) * cos_th;
    assign px_prod = rs_reg * cp_reg;
    assign py_prod = rs_reg * sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // floor shifts: take the upper bits of the products
            rs_reg  <= rs_prod[55:26];
            pz_reg  <= pz_prod[55:26];
            cp_reg  <= cos_ph;
            sp_reg  <= sin_ph;
            px_reg  <= px_prod[59:30];
            py_reg  <= py_prod[59:30];
            pz2_reg <= pz_reg;
        end
    end

    // ---------------- squared distance ----------------
    function automatic logic [29:0] mag30(input logic [30:0] v);
        return v[30] ? 30'(-v) : v[29:0];
    endfunction

    logic [30:0]      dx;
    logic [30:0]      dy;
    logic [30:0]      dz;
    logic [29:0]      ax_reg;
    logic [29:0]      ay_reg;
    logic [29:0]      az_reg;
    logic [59:0]      sqx_reg;
    logic [59:0]      sqy_reg;
    logic [59:0]      sqz_reg;

    assign dx = {{3{center_x_reg[23]}}, center_x_reg, 4'b0000} - {px_reg[29], px_reg};
    assign dy = {{3{center_y_reg[23]}}, center_y_reg, 4'b0000} - {py_reg[29], py_reg};
    assign dz = {{3{center_z_reg[23]}}, center_z_reg, 4'b0000} - {pz2_reg[29], pz2_reg};

    logic [SUM_W-1:0] rt_rem_reg [SQ_N+1];
    logic [SUM_W-1:0] rt_res_reg [SQ_N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg        <= mag30(dx);
            ay_reg        <= mag30(dy);
            az_reg        <= mag30(dz);
            sqx_reg       <= ax_reg * ax_reg;
            sqy_reg       <= ay_reg * ay_reg;
            sqz_reg       <= az_reg * az_reg;
            rt_rem_reg[0] <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            rt_res_reg[0] <= '0;
        end
    end

    // ---------------- integer square root, one result bit per stage ----------------
    for (genvar i = 1; i <= SQ_N; i++)
    begin : g_root
        localparam logic [SUM_W-1:0] BIT_V = SUM_W'(1) << (2 * (SQ_N - i));
        logic [SUM_W-1:0] trial;
        assign trial = rt_res_reg[i-1] + BIT_V;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rt_rem_reg[i-1] >= trial)
                begin
                    rt_rem_reg[i] <= rt_rem_reg[i-1] - trial;
                    rt_res_reg[i] <= (rt_res_reg[i-1] >> 1) + BIT_V;
                end
                else
                begin
                    rt_rem_reg[i] <= rt_rem_reg[i-1];
                    rt_res_reg[i] <= rt_res_reg[i-1] >> 1;
                end
            end
        end
    end

    // ---------------- surface distance and range check ----------------
    logic [DIST_W-1:0] dist_root;
    logic [DIST_W-1:0] rad;
    logic [DIST_W-1:0] hq4;
    logic [DIST_W-1:0] dsurf;
    logic [26:0]       hq;

    assign dist_root = rt_res_reg[SQ_N][DIST_W-1:0];
    assign rad       = DIST_W'({ball_radius_reg, 4'b0000});
    assign hq        = {half_width_reg, 4'b0000};
    assign hq4       = DIST_W'({hq, 2'b00});
    assign dsurf     = (dist_root > rad) ? (dist_root - rad) : '0;

    gsae_pkg::tag_t    tag_reg [P_D:P_OUT];
    logic [DIV_W-1:0]  dv_rem_reg [DIV_N+1];
    logic [DIV_N-1:0]  q_reg [DIV_N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[P_D]  <= gsae_pkg::tag_t'({dsurf > hq4, dsurf == '0});
            dv_rem_reg[0] <= {dsurf, 16'h0000};
            q_reg[0]      <= '0;
            for (int j = P_D + 1; j <= P_OUT; j++)
            begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end
    end

    // ---------------- restoring divider: q = d * 2^16 / H ----------------
    // Out-of-range or zero-distance items produce a quotient that is ignored.
    for (genvar j = 1; j <= DIV_N; j++)
    begin : g_div
        logic [DIV_W-1:0] sub;
        assign sub = DIV_W'(hq) << (DIV_N - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (dv_rem_reg[j-1] >= sub)
                begin
                    dv_rem_reg[j] <= dv_rem_reg[j-1] - sub;
                    q_reg[j]      <= q_reg[j-1] | (DIV_N'(1) << (DIV_N - j));
                end
                else
                begin
                    dv_rem_reg[j] <= dv_rem_reg[j-1];
                    q_reg[j]      <= q_reg[j-1];
                end
            end
        end
    end

    // ---------------- t = q^2, split into integer and fraction ----------------
    logic [2*DIV_N-1:0] tsq;
    logic [5:0]         n_reg [P_T:P_EXP];
    logic [FRAC-1:0]    f_reg [P_T:P_EXP];
    logic [GW-1:0]      g_reg [EXP_N+1];

    assign tsq = q_reg[DIV_N] * q_reg[DIV_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[P_T] <= tsq[2*FRAC+5:2*FRAC];
            f_reg[P_T] <= tsq[2*FRAC-1:FRAC];
            g_reg[0]   <= gsae_pkg::ONE_Q30;
            for (int j = P_T + 1; j <= P_EXP; j++)
            begin
                n_reg[j] <= n_reg[j-1];
                f_reg[j] <= f_reg[j-1];
            end
        end
    end

    // ---------------- 2^-f: one fraction bit per stage ----------------
    for (genvar k = 1; k <= EXP_N; k++)
    begin : g_exp
        logic [2*GW-1:0] prod;
        assign prod = g_reg[k-1] * gsae_pkg::EXP_ROM[k-1];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (f_reg[P_T + k - 1][FRAC - k])
                begin
                    g_reg[k] <= prod[GW+29:30];
                end
                else
                begin
                    g_reg[k] <= g_reg[k-1];
                end
            end
        end
    end

    // ---------------- 2^-n, scale and round toward zero ----------------
    logic [GW-1:0]      gs_reg;
    logic signed [63:0] val_prod;
    logic signed [63:0] val_reg;
    logic signed [63:0] val_rnd;
    logic               in_range_reg;
    logic signed [31:0] perturbation_reg;

    assign val_prod = value_inside_reg * $signed({1'b0, gs_reg});
    assign val_rnd  = val_reg[63] ? (val_reg + 64'sd1073741823) : val_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a point inside the ball keeps the full value, zero width too
            gs_reg  <= tag_reg[P_SH-1].dz ? gsae_pkg::ONE_Q30
                                          : (g_reg[EXP_N] >> n_reg[P_EXP]);
            val_reg <= val_prod;
            in_range_reg     <= !tag_reg[P_OUT-1].oor;
            perturbation_reg <= tag_reg[P_OUT-1].oor ? '0 : val_rnd[61:30];
        end
    end

    assign out_valid    = vld_reg[P_OUT];
    assign in_range     = in_range_reg;
    assign perturbation = perturbation_reg;

endmodule

@@ hdl/gsae_checker.sv @@
// Port-level checks for gaussian_sphere_anomaly_eval, attached by bind.
// Depends only on the top level's port list.
module gsae_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               in_range,
    input logic signed [31:0] perturbation
);

    // hold a result that was not taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(perturbation) && $stable(in_range))
        else $error("result changed while stalled");

    // drop the value for points out of range
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> perturbation == 32'sd0)
        else $error("out-of-range result carries a value");

    // a held result blocks new transfers
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // an empty output stage never blocks the input
    a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind gaussian_sphere_anomaly_eval gsae_checker u_gsae_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .in_range     (in_range),
    .perturbation (perturbation)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_sphere_anomaly_eval: random and directed query points,
// predicted in integer arithmetic and compared in order. Depends on gsae_pkg and the RTL.
module tb_top;

    typedef struct {
        logic        in_range;
        logic [31:0] perturbation;
    } anomaly_t;

    // Scoreboard: holds the taper predictor, its own copy of the registers and the expected queue.
    class anomaly_scoreboard;
        longint    cx, cy, cz;
        longint    core_r, hwhm;
        longint    val_core;
        anomaly_t  pending[$];
        int        errors;

        function new();
            cx = 0; cy = 0; cz = 0; core_r = 0; hwhm = 0; val_core = 0; errors = 0;
        endfunction

        function void set_reg(gsae_pkg::cfg_reg_t idx, logic [31:0] data);
            case (idx)
                gsae_pkg::REG_CENTER_X:     cx = longint'($signed(data[23:0]));
                gsae_pkg::REG_CENTER_Y:     cy = longint'($signed(data[23:0]));
                gsae_pkg::REG_CENTER_Z:     cz = longint'($signed(data[23:0]));
                gsae_pkg::REG_BALL_RADIUS:  core_r = longint'(data[22:0]);
                gsae_pkg::REG_HALF_WIDTH:   hwhm = longint'(data[22:0]);
                gsae_pkg::REG_VALUE_INSIDE: val_core = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // Rotation-mode CORDIC on a 16-bit binary angle; folds the back half-plane first.
        function void rotate(logic [15:0] ang, output longint s, output longint c);
            logic [31:0] a;
            logic        flip;
            longint      x, y, z, nx, ny;
            longint      tbl[24];
            tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
            a = {ang, 16'h0};
            flip = a[31] ^ a[30];
            if (flip)
                a = a + 32'h8000_0000;
            z = longint'($signed(a));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 24; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= tbl[i];
                end
                else
                begin
                    nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += tbl[i];
                end
                x = nx; y = ny;
            end
            if (flip)
            begin
                x = -x; y = -y;
            end
            s = y; c = x;
        endfunction

        function logic [63:0] sq(longint v);
            logic [63:0] m;
            m = v < 0 ? -v : v;
            return m * m;
        endfunction

        function anomaly_t taper(logic [22:0] r_in, logic [15:0] th, logic [15:0] ph);
            anomaly_t    res;
            longint      r, st, ct, sp, cp, rs, px, py, pz, v;
            logic [63:0] sum, root_d, rad, d, hq, g, q, t, f, c, n;
            r = longint'(r_in);
            rotate(th, st, ct);
            rotate(ph, sp, cp);
            rs = floor_shr(r * st, 26);
            px = floor_shr(rs * cp, 30);
            py = floor_shr(rs * sp, 30);
            pz = floor_shr(r * ct, 26);
            sum = sq(cx * 16 - px) + sq(cy * 16 - py) + sq(cz * 16 - pz);
            root_d = root(sum);
            rad = core_r * 16;
            d = root_d > rad ? root_d - rad : 0;
            hq = hwhm * 16;
            if (d > 4 * hq)
            begin
                res.in_range = 1'b0;
                res.perturbation = '0;
                return res;
            end
            g = 64'd1 << 30;
            if (d != 0)
            begin
                q = (d << 16) / hq;
                t = (q * q) >> 16;
                n = (t >> 16) & 64'h3f;
                f = t & 64'hffff;
                c = root(64'd1 << 59);
                for (int k = 1; k <= 16; k++)
                begin
                    if (f[16-k])
                        g = (g * c) >> 30;
                    c = root(c << 30);
                end
                g = n < 63 ? g >> n : 0;
            end
            v = (val_core * longint'(g)) / (64'sd1 <<< 30);
            res.in_range = 1'b1;
            res.perturbation = v[31:0];
            return res;
        endfunction

        function void note_point(logic [22:0] r, logic [15:0] th, logic [15:0] ph);
            pending.push_back(taper(r, th, ph));
        endfunction

        function void check_result(logic rng, logic [31:0] pert);
            anomaly_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing pending: in_range %0b perturbation %0d",
                         $time, rng, $signed(pert));
                errors++;
                return;
            end
            e = pending.pop_front();
            if (rng !== e.in_range)
            begin
                $display("%0t: in_range expected %0b actual %0b", $time, e.in_range, rng);
                errors++;
            end
            if (pert !== e.perturbation)
            begin
                $display("%0t: perturbation expected %0d actual %0d", $time,
                         $signed(e.perturbation), $signed(pert));
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [22:0]        point_radius;
    logic [15:0]        colatitude;
    logic [15:0]        longitude;
    logic               out_valid;
    logic               out_ready;
    logic               in_range;
    logic signed [31:0] perturbation;

    anomaly_scoreboard sb;
    int                hold_off;   // receiver hold-off request, in cycles
    int                n_points;
    int                n_results;
    longint            cycles;

    gaussian_sphere_anomaly_eval u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: no correct run gets near this many cycles.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stall per result, plus a long hold-off when the stimulus asks for one.
    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            // leave on a transfer, or early when a hold-off is requested
            while (!out_valid && hold_off == 0)
                @(posedge clk);
        end
    end

    // Check each result transfer as it happens.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(in_range, perturbation);
            n_results++;
        end
    end

    task automatic write_reg(gsae_pkg::cfg_reg_t idx, logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Offer one point; hold valid and payload until the transfer.
    task automatic send_point(logic [22:0] r, logic [15:0] th, logic [15:0] ph, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        point_radius <= r;
        colatitude   <= th;
        longitude    <= ph;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(r, th, ph);
        n_points++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_gap(output int g);
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    endtask

    // Configuration: centre in a cube of half side scale, random core and taper.
    task automatic setup_ball(int scale, logic [31:0] vin);
        logic [31:0] bx, by;
        bx = $urandom_range(0, 2 * scale) - scale;
        by = $urandom_range(0, 2 * scale) - scale;
        write_reg(gsae_pkg::REG_CENTER_X, bx);
        write_reg(gsae_pkg::REG_CENTER_Y, by);
        write_reg(gsae_pkg::REG_CENTER_Z, $urandom_range(0, 2 * scale) - scale);
        write_reg(gsae_pkg::REG_BALL_RADIUS, $urandom_range(0, scale / 4));
        write_reg(gsae_pkg::REG_HALF_WIDTH, $urandom_range(0, scale / 4));
        write_reg(gsae_pkg::REG_VALUE_INSIDE, vin);
    endtask

    initial
    begin
        int          g;
        int          scale;
        int          n_items;
        logic [31:0] vin;
        sb           = new();
        hold_off     = 0;
        n_points     = 0;
        n_results    = 0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = gsae_pkg::REG_CENTER_X;
        cfg_data     = '0;
        in_valid     = 1'b0;
        point_radius = '0;
        colatitude   = '0;
        longitude    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings (zero half width), field extremes and odd colatitudes.
        send_point(23'd0, 16'd0, 16'd0, 0);
        send_point(23'h7fffff, 16'd32768, 16'hffff, 0);
        send_point(23'h7fffff, 16'hffff, 16'd16384, 1);
        drain();
        write_reg(gsae_pkg::REG_VALUE_INSIDE, 32'h7fffffff);
        write_reg(gsae_pkg::REG_HALF_WIDTH, 23'h7fffff);
        write_reg(gsae_pkg::REG_BALL_RADIUS, 23'd0);
        send_point(23'd0, 16'd0, 16'd0, 0);                  // centre of the ball
        send_point(23'h7fffff, 16'd16384, 16'd0, 0);
        send_point(23'h7fffff, 16'd49152, 16'd49152, 0);     // colatitude past pi
        send_point(23'h2aaaaa, 16'h5555, 16'haaaa, 0);
        drain();
        write_reg(gsae_pkg::REG_CENTER_X, 32'h00800000);
        write_reg(gsae_pkg::REG_CENTER_Y, 32'h007fffff);
        write_reg(gsae_pkg::REG_CENTER_Z, 32'h00800000);
        write_reg(gsae_pkg::REG_BALL_RADIUS, 23'h7fffff);
        write_reg(gsae_pkg::REG_VALUE_INSIDE, 32'h80000000);
        write_reg(gsae_pkg::REG_HALF_WIDTH, 23'd0);
        write_reg(gsae_pkg::cfg_reg_t'(3'd7), 32'hffffffff); // unmapped index: drop
        send_point(23'h7fffff, 16'd32768, 16'd32768, 0);
        send_point(23'd100, 16'd8192, 16'd8192, 0);
        drain();
        write_reg(gsae_pkg::REG_BALL_RADIUS, 23'd0);
        send_point(23'd5, 16'd1, 16'hffff, 0);               // far out, zero taper
        drain();
        write_reg(gsae_pkg::REG_HALF_WIDTH, 23'd1);
        send_point(23'd1, 16'd100, 16'd200, 0);

        // Random phases: several ball settings, points mostly near the ball so the taper bites.
        for (int ph = 0; ph < 20; ph++)
        begin
            drain();
            scale = (ph % 4 == 0) ? 8388607 : $urandom_range(16, 4000);
            vin = (ph % 5 == 1) ? 32'h7fffffff : (ph % 5 == 2) ? 32'h80000000 : $urandom();
            setup_ball(scale, vin);
            n_items = (ph == 3) ? 160 : 97;
            if (ph == 3)
                hold_off = 300;   // block fills and stalls its input meanwhile
            for (int i = 0; i < n_items; i++)
            begin
                random_gap(g);
                if (ph % 3 == 0)
                    g = 0;
                if ($urandom_range(0, 9) == 0)
                    send_point(23'($urandom()), 16'($urandom()), 16'($urandom()), g);
                else
                    send_point(23'($urandom_range(0, 2 * scale > 8388607 ? 8388607 : 2 * scale)),
                               16'($urandom_range(0, 32768)), 16'($urandom()), g);
            end
        end
        drain();

        $display("Covered %0d query points and %0d results over 20 ball settings plus edges.",
                 n_points, n_results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ gaussian_sphere_anomaly_eval.f @@
hdl/gsae_pkg.sv
hdl/gsae_cordic.sv
hdl/gaussian_sphere_anomaly_eval.sv
hdl/gsae_checker.sv
tb/sv/tb_top.sv
